// ===== src/hpc_pkg.sv =====
// Shared constants, tables and types for the Halton coordinate pipeline.
`timescale 1ns / 1ps
`default_nettype none
package hpc_pkg;

	localparam int HPC_INDEX_BITS  = 24;
	localparam int HPC_PRIME_COUNT = 25;
	localparam int HPC_TABLE_SIZE  = 25;
	localparam int HPC_DIV_BITS    = 4;
	localparam int HPC_DIV_STAGES  = 32 / HPC_DIV_BITS;

	localparam logic [6:0] HPC_PRIMES [HPC_TABLE_SIZE] = '{
		7'd2, 7'd3, 7'd5, 7'd7, 7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29,
		7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61, 7'd67, 7'd71,
		7'd73, 7'd79, 7'd83, 7'd89, 7'd97
	};

	// floor(2^32 / prime), used for the quotient estimate of each digit
	localparam logic [31:0] HPC_RECIP [HPC_TABLE_SIZE] = '{
		32'd2147483648, 32'd1431655765, 32'd858993459, 32'd613566756,
		32'd390451572,  32'd330382099,  32'd252645135, 32'd226050910,
		32'd186737708,  32'd148102320,  32'd138547332, 32'd116080197,
		32'd104755299,  32'd99882960,   32'd91382282,  32'd81037118,
		32'd72796055,   32'd70409299,   32'd64103989,  32'd60492497,
		32'd58835168,   32'd54366674,   32'd51746593,  32'd48258059,
		32'd44278013
	};

	// Request data that rides alongside the arithmetic
	typedef struct packed {
		logic               bad;
		logic [6:0]         base;
		logic [31:0]        recip;
		logic signed [31:0] lower;
		logic signed [32:0] span;
	} hpc_side_t;

endpackage
`default_nettype wire

// ===== src/hpc_digit.sv =====
// One base-b digit of the reversal: quotient estimate, correction, accumulate.
`timescale 1ns / 1ps
`default_nettype none
module hpc_digit #(
	parameter int M_W   = hpc_pkg::HPC_INDEX_BITS,
	parameter int DEN_W = hpc_pkg::HPC_INDEX_BITS + 7
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    in_vld,
	input  hpc_pkg::hpc_side_t     in_side,
	input  wire  [M_W-1:0]         in_m,
	input  wire  [DEN_W-1:0]       in_rev,
	input  wire  [DEN_W-1:0]       in_den,
	output logic                   out_vld,
	output hpc_pkg::hpc_side_t     out_side,
	output logic [M_W-1:0]         out_m,
	output logic [DEN_W-1:0]       out_rev,
	output logic [DEN_W-1:0]       out_den
);
	localparam int PW = M_W + 32;

	logic               vld_s1, vld_s2;
	hpc_pkg::hpc_side_t side_s1, side_s2;
	logic [M_W-1:0]     m_s1, m_s2, q0_s2, qb_s2;
	logic [PW-1:0]      prod_s1;
	logic [DEN_W-1:0]   rev_s1, den_s1, revb_s1, denb_s1;
	logic [DEN_W-1:0]   rev_s2, den_s2, revb_s2, denb_s2;
	logic               nz_s1, nz_s2;
	logic [M_W-1:0]     r_raw, r_fix, q_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			m_s1    <= in_m;
			rev_s1  <= in_rev;
			den_s1  <= in_den;
			nz_s1   <= (in_m != '0);
			prod_s1 <= PW'(in_m) * PW'(in_side.recip);
			revb_s1 <= in_rev * DEN_W'(in_side.base);
			denb_s1 <= in_den * DEN_W'(in_side.base);

			side_s2 <= side_s1;
			m_s2    <= m_s1;
			rev_s2  <= rev_s1;
			den_s2  <= den_s1;
			nz_s2   <= nz_s1;
			revb_s2 <= revb_s1;
			denb_s2 <= denb_s1;
			q0_s2   <= prod_s1[PW-1:32];
			qb_s2   <= prod_s1[PW-1:32] * M_W'(side_s1.base);
		end
	end

	// estimate is low by at most one: fix remainder and quotient
	always_comb begin
		r_raw = m_s2 - qb_s2;
		if (r_raw >= M_W'(side_s2.base)) begin
			r_fix = r_raw - M_W'(side_s2.base);
			q_fix = q0_s2 + M_W'(1);
		end else begin
			r_fix = r_raw;
			q_fix = q0_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= side_s2;
			if (nz_s2) begin
				out_m   <= q_fix;
				out_rev <= revb_s2 + DEN_W'(r_fix);
				out_den <= denb_s2;
			end else begin
				out_m   <= m_s2;
				out_rev <= rev_s2;
				out_den <= den_s2;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/hpc_div.sv =====
// One stage of the restoring division rev / den, HPC_DIV_BITS (4) quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module hpc_div #(
	parameter int DEN_W = hpc_pkg::HPC_INDEX_BITS + 7
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    in_vld,
	input  hpc_pkg::hpc_side_t     in_side,
	input  wire  [DEN_W-1:0]       in_rem,
	input  wire  [DEN_W-1:0]       in_den,
	input  wire  [31:0]            in_frac,
	output logic                   out_vld,
	output hpc_pkg::hpc_side_t     out_side,
	output logic [DEN_W-1:0]       out_rem,
	output logic [DEN_W-1:0]       out_den,
	output logic [31:0]            out_frac
);
	logic [DEN_W:0] r_t;
	logic [31:0]    f_t;

	always_comb begin
		r_t = {1'b0, in_rem};
		f_t = in_frac;
		for (int i = 0; i < hpc_pkg::HPC_DIV_BITS; i++) begin
			r_t = {r_t[DEN_W-1:0], 1'b0};
			f_t = {f_t[30:0], 1'b0};
			if (r_t >= {1'b0, in_den}) begin
				r_t    = r_t - {1'b0, in_den};
				f_t[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			out_rem  <= r_t[DEN_W-1:0];
			out_den  <= in_den;
			out_frac <= f_t;
		end
	end

endmodule
`default_nettype wire

// ===== src/halton_point_coordinate_top.sv =====
// Top level: Halton radical inverse and box scaling, fully pipelined.
// From input request to result: one decode stage, three stages per base digit, eight
// division stages (4 bits each), two multiply/add stages and the output register.
// Throughput is one request a cycle; a blocked output holds the whole pipeline. Reset
// clears all valid bits and sets dims_in_use to 1; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module halton_point_coordinate_top #(
	parameter int INDEX_BITS  = hpc_pkg::HPC_INDEX_BITS,
	parameter int PRIME_COUNT = hpc_pkg::HPC_PRIME_COUNT
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire  [4:0]             cfg_wr_data,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [INDEX_BITS-1:0]  point_index,
	input  wire  [4:0]             coord_index,
	input  wire                    second_set,
	input  wire  signed [31:0]     lower_bound,
	input  wire  signed [31:0]     upper_bound,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic signed [31:0]     coordinate,
	output logic [31:0]            fraction,
	output logic [6:0]             prime_used,
	output logic                   bad_request
);
	localparam int DEN_W = INDEX_BITS + 7;
	localparam int NDIV  = hpc_pkg::HPC_DIV_STAGES;

	logic       en;
	logic [4:0] dims_in_use_q;

	logic [5:0]         bidx;
	hpc_pkg::hpc_side_t side_d;

	logic                vld_c  [INDEX_BITS+1];
	hpc_pkg::hpc_side_t  side_c [INDEX_BITS+1];
	logic [INDEX_BITS-1:0] m_c  [INDEX_BITS+1];
	logic [DEN_W-1:0]    rev_c  [INDEX_BITS+1];
	logic [DEN_W-1:0]    den_c  [INDEX_BITS+1];

	logic                dvld_c  [NDIV+1];
	hpc_pkg::hpc_side_t  dside_c [NDIV+1];
	logic [DEN_W-1:0]    drem_c  [NDIV+1];
	logic [DEN_W-1:0]    dden_c  [NDIV+1];
	logic [31:0]         dfrac_c [NDIV+1];

	logic               vld_s1, vld_s2;
	hpc_pkg::hpc_side_t side_s1, side_s2;
	logic [31:0]        frac_s1, frac_s2;
	logic signed [49:0] hi_s1, lo_s1, sum_s2;

	// advance everything unless a finished result is held
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_in_use_q <= 5'd1;
		end else if (cfg_wr_en) begin
			dims_in_use_q <= cfg_wr_data;
		end
	end

	always_comb begin
		bidx = {1'b0, coord_index} + (second_set ? {1'b0, dims_in_use_q} : 6'd0);
		side_d.bad   = (coord_index >= dims_in_use_q) || (32'(bidx) >= PRIME_COUNT);
		side_d.base  = side_d.bad ? 7'd0 : hpc_pkg::HPC_PRIMES[bidx[4:0]];
		side_d.recip = side_d.bad ? 32'd0 : hpc_pkg::HPC_RECIP[bidx[4:0]];
		side_d.lower = lower_bound;
		side_d.span  = 33'(upper_bound) - 33'(lower_bound);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (en) begin
			vld_c[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_c[0] <= side_d;
			m_c[0]    <= point_index;
			rev_c[0]  <= '0;
			den_c[0]  <= DEN_W'(1);
		end
	end

	for (genvar g = 0; g < INDEX_BITS; g++) begin : g_digit
		hpc_digit #(.M_W(INDEX_BITS), .DEN_W(DEN_W)) u_digit (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld_c[g]),
			.in_side  (side_c[g]),
			.in_m     (m_c[g]),
			.in_rev   (rev_c[g]),
			.in_den   (den_c[g]),
			.out_vld  (vld_c[g+1]),
			.out_side (side_c[g+1]),
			.out_m    (m_c[g+1]),
			.out_rev  (rev_c[g+1]),
			.out_den  (den_c[g+1])
		);
	end

	assign dvld_c[0]  = vld_c[INDEX_BITS];
	assign dside_c[0] = side_c[INDEX_BITS];
	assign drem_c[0]  = rev_c[INDEX_BITS];
	assign dden_c[0]  = den_c[INDEX_BITS];
	assign dfrac_c[0] = '0;

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		hpc_div #(.DEN_W(DEN_W)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (dvld_c[g]),
			.in_side  (dside_c[g]),
			.in_rem   (drem_c[g]),
			.in_den   (dden_c[g]),
			.in_frac  (dfrac_c[g]),
			.out_vld  (dvld_c[g+1]),
			.out_side (dside_c[g+1]),
			.out_rem  (drem_c[g+1]),
			.out_den  (dden_c[g+1]),
			.out_frac (dfrac_c[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= dvld_c[NDIV];
			vld_s2    <= vld_s1;
			out_valid <= vld_s2;
		end
	end

	// split fraction into halves so each product stays narrow
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= dside_c[NDIV];
			frac_s1 <= dfrac_c[NDIV];
			hi_s1   <= 50'($signed({1'b0, dfrac_c[NDIV][31:16]})) * 50'(dside_c[NDIV].span);
			lo_s1   <= 50'($signed({1'b0, dfrac_c[NDIV][15:0]})) * 50'(dside_c[NDIV].span);

			side_s2 <= side_s1;
			frac_s2 <= frac_s1;
			sum_s2  <= hi_s1 + (lo_s1 >>> 16);

			bad_request <= side_s2.bad;
			if (side_s2.bad) begin
				coordinate <= '0;
				fraction   <= '0;
				prime_used <= '0;
			end else begin
				coordinate <= side_s2.lower + sum_s2[47:16];
				fraction   <= frac_s2;
				prime_used <= side_s2.base;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/hpc_checker.sv =====
// Port-level checks for the Halton coordinate block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hpc_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_ready,
	input wire                   out_valid,
	input wire                   out_ready,
	input wire signed [31:0]     coordinate,
	input wire [31:0]            fraction,
	input wire [6:0]             prime_used,
	input wire                   bad_request
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coordinate) && $stable(fraction))
		else $error("result changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> coordinate == 0 && fraction == 0 && prime_used == 0)
		else $error("bad request with non-zero fields");

	a_good_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_request |-> prime_used != 0)
		else $error("good request with no prime");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind halton_point_coordinate_top hpc_checker u_hpc_checker (.*);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the Halton point coordinate block.
`timescale 1ns / 1ps
module tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 120;

	typedef struct packed {
		logic [23:0]        idx;
		logic [4:0]         coord;
		logic               second;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} req_t;

	typedef struct packed {
		logic signed [31:0] coord;
		logic [31:0]        frac;
		logic [6:0]         prime;
		logic               bad;
	} res_t;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [4:0] cfg_wr_data;
	logic in_valid, in_ready;
	logic [23:0] point_index;
	logic [4:0] coord_index;
	logic second_set;
	logic signed [31:0] lower_bound, upper_bound;
	logic out_valid, out_ready;
	logic signed [31:0] coordinate;
	logic [31:0] fraction;
	logic [6:0] prime_used;
	logic bad_request;

	halton_point_coordinate_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_index(point_index), .coord_index(coord_index), .second_set(second_set),
		.lower_bound(lower_bound), .upper_bound(upper_bound),
		.out_valid(out_valid), .out_ready(out_ready),
		.coordinate(coordinate), .fraction(fraction),
		.prime_used(prime_used), .bad_request(bad_request)
	);

	req_t pending_reqs[$];
	res_t expected_coords[$];
	logic [4:0] dims_model;
	int errors = 0;
	int hold_sender = 0;
	int stall_len = 0;
	int gap_len = 0;
	int long_stall_req = 0;
	logic long_stall_done;
	int idle_cycles = 0;
	logic timed_out = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_draw();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	// Work out one coordinate as the block should.
	function automatic res_t halton_coord(req_t r, logic [4:0] dims);
		res_t o;
		logic [5:0] bidx;
		logic [63:0] base, m, rev, den, rem, frac;
		logic signed [63:0] span, hi_p, lo_p, sum;
		o = '0;
		bidx = r.coord + (r.second ? dims : 5'd0);
		if (r.coord >= dims || bidx >= 25) begin
			o.bad = 1'b1;
			return o;
		end
		base = 64'(hpc_pkg::HPC_PRIMES[bidx]);
		m = 64'(r.idx);
		rev = 0;
		den = 1;
		while (m > 0) begin
			rev = rev * base + (m % base);
			m = m / base;
			den = den * base;
		end
		rem = rev;
		frac = 0;
		for (int i = 0; i < 32; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= den) begin
				rem = rem - den;
				frac[0] = 1'b1;
			end
		end
		frac = frac & 64'hFFFF_FFFF;
		span = 64'(r.hi) - 64'(r.lo);
		hi_p = $signed({48'd0, frac[31:16]}) * span;
		lo_p = $signed({48'd0, frac[15:0]}) * span;
		sum = hi_p + (lo_p >>> 16);
		o.coord = 32'(64'(r.lo) + (sum >>> 16));
		o.frac = frac[31:0];
		o.prime = base[6:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// Driver: hold each request until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			point_index <= '0;
			coord_index <= '0;
			second_set <= 1'b0;
			lower_bound <= '0;
			upper_bound <= '0;
			gap_len <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_coords.push_back(halton_coord({point_index, coord_index,
					second_set, lower_bound, upper_bound}, dims_model));
			end
			if (!in_valid || in_ready) begin
				if (gap_len > 0) begin
					gap_len <= gap_len - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && hold_sender == 0) begin
					req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					point_index <= r.idx;
					coord_index <= r.coord;
					second_set <= r.second;
					lower_bound <= r.lo;
					upper_bound <= r.hi;
					gap_len <= gap_draw();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_len <= 0;
			long_stall_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_coords.size() == 0) begin
					report_mismatch("unexpected result", fraction, 32'd0);
				end else begin
					res_t e;
					e = expected_coords.pop_front();
					if (coordinate !== e.coord) report_mismatch("coordinate", coordinate, e.coord);
					if (fraction !== e.frac) report_mismatch("fraction", fraction, e.frac);
					if (prime_used !== e.prime) report_mismatch("prime", 32'(prime_used), 32'(e.prime));
					if (bad_request !== e.bad) report_mismatch("bad", 32'(bad_request), 32'(e.bad));
				end
			end
			if (long_stall_req > 0 && !long_stall_done) begin
				out_ready <= 1'b0;
				stall_len <= 400;
				long_stall_done <= 1'b1;
			end else if (stall_len > 0) begin
				out_ready <= 1'b0;
				stall_len <= stall_len - 1;
			end else begin
				out_ready <= 1'b1;
				stall_len <= gap_draw();
			end
		end
	end

	// Watchdog: count cycles with no request or result moving.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				timed_out <= 1'b1;
			end
		end
	end

	function automatic req_t random_req(logic [4:0] dims);
		req_t r;
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: r.idx = 24'hFFFFFF;
			1: r.idx = 24'd0;
			2, 3: r.idx = 24'($urandom_range(0, 255));
			default: r.idx = 24'($urandom);
		endcase
		if ($urandom_range(0, 7) == 0) r.coord = 5'($urandom);
		else r.coord = 5'($urandom_range(0, (dims == 0) ? 0 : dims - 1));
		r.second = 1'($urandom);
		r.lo = $signed($urandom);
		r.hi = $signed($urandom);
		if ($urandom_range(0, 3) == 0) begin
			r.lo = 32'sh0;
			r.hi = 32'sh10000;
		end
		return r;
	endfunction

	task automatic wait_drained();
		while ((pending_reqs.size() > 0 || in_valid || expected_coords.size() > 0)
			&& !timed_out)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(logic [4:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		dims_model = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [4:0] dims_set [6] = '{5'd25, 5'd0, 5'd13, 5'd31, 5'd3, 5'd1};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		dims_model = 5'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, zero index, reversed bounds, bad requests.
		pending_reqs.push_back('{24'd0, 5'd0, 1'b0, 32'sh1234, 32'sh5678});
		pending_reqs.push_back('{24'hFFFFFF, 5'd0, 1'b0, 32'sh80000000, 32'sh7FFFFFFF});
		pending_reqs.push_back('{24'hFFFFFF, 5'd0, 1'b0, 32'sh7FFFFFFF, 32'sh80000000});
		pending_reqs.push_back('{24'd1, 5'd0, 1'b1, 32'sh0, 32'sh10000});
		pending_reqs.push_back('{24'd5, 5'd1, 1'b0, 32'sh0, 32'sh10000});
		pending_reqs.push_back('{24'd7, 5'd31, 1'b1, 32'sh0, 32'sh10000});
		pending_reqs.push_back('{24'hAAAAAA, 5'd0, 1'b0, -32'sh30000, -32'sh50000});
		wait_drained();
		write_dims(5'd25);
		for (int c = 0; c < 25; c++)
			pending_reqs.push_back('{24'($urandom), 5'(c), 1'b0, 32'sh0, 32'sh10000});
		pending_reqs.push_back('{24'd9, 5'd0, 1'b1, 32'sh0, 32'sh10000});
		wait_drained();

		foreach (dims_set[k]) begin
			write_dims(dims_set[k]);
			// Long receiver stall while the sender keeps offering requests.
			if (k == 2) long_stall_req = 1;
			if (k == 4) begin
				for (int i = 0; i < 160; i++) pending_reqs.push_back(random_req(dims_model));
				// Sender pause until every expected result has arrived.
				while (pending_reqs.size() > 0 && !timed_out) @(posedge clk);
				hold_sender = 1;
				while ((in_valid || expected_coords.size() > 0) && !timed_out) @(posedge clk);
				hold_sender = 0;
				for (int i = 0; i < 160; i++) pending_reqs.push_back(random_req(dims_model));
			end else begin
				for (int i = 0; i < 320; i++) pending_reqs.push_back(random_req(dims_model));
			end
			wait_drained();
		end

		if (!timed_out && errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (timed_out) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

// ===== files.f =====
src/hpc_pkg.sv
src/hpc_digit.sv
src/hpc_div.sv
src/halton_point_coordinate_top.sv
src/hpc_checker.sv
verif/tb.sv
